@@ rtl/core/hcm_pkg.sv @@
// Package: shared types and constants of the dB heat-map colormap.
`default_nettype none
package hcm_pkg;
  localparam int NORM_STEPS  = 15;
  localparam int BLEND_STEPS = 8;
  localparam int NUM_CH      = 3;
  localparam logic [15:0] NORM_ONE    = 16'h8000;
  localparam logic [15:0] FLOOR_RESET = 16'h9C00;

  typedef enum logic [2:0] {
    REG_THRESH  = 3'd0,
    REG_COLOR_0 = 3'd1,
    REG_COLOR_1 = 3'd2,
    REG_COLOR_2 = 3'd3,
    REG_COLOR_3 = 3'd4,
    REG_COLOR_4 = 3'd5,
    REG_FLOOR   = 3'd6,
    REG_CEILING = 3'd7
  } hcm_reg_e;

  // remainder, divisor, and a shift word: dividend bits leave at the top,
  // quotient bits enter at the bottom
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] den;
    logic [15:0] quo;
  } hcm_div_t;
endpackage
`default_nettype wire

@@ rtl/core/hcm_stream_if.sv @@
// Interfaces: level input channel and pixel output channel.
`default_nettype none
interface hcm_level_if;
  logic        valid;
  logic        ready;
  logic [15:0] db_value;
  modport source (output valid, output db_value, input ready);
  modport sink (input valid, input db_value, output ready);
endinterface

interface hcm_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

@@ rtl/core/hcm_div_cell.sv @@
// Registered restoring divide cell: a quotient bit per en cycle.
`default_nettype none
module hcm_div_cell (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire hcm_pkg::hcm_div_t din,
  output hcm_pkg::hcm_div_t      dout
);
  logic [16:0] trial;
  logic        ge;
  logic [16:0] diff;

  always_comb begin
    trial = {din.rem, din.quo[15]};
    ge    = trial >= {1'b0, din.den};
    diff  = trial - {1'b0, din.den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= ge ? diff[15:0] : trial[15:0];
      dout.den <= din.den;
      dout.quo <= {din.quo[14:0], ge};
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/db_heatmap_colormap_core.sv @@
// Top level: dB level to heat-map RGB pixel, pipelined divider chains.
//
//  channel  dir  payload                 handshake
//  level    in   db_value  s16 Q8.8      valid/ready
//  pixel    out  red, green, blue  u8    valid/ready
//  cfg      in   cfg_index 3b, data 64b  cfg_we only
//
// One item per cycle unless stalled; stages: prep, 15 normalize cells,
// segment select, multiply, 8 blend cells per channel, output register.
// The whole pipeline advances together; a stalled output freezes it.
// rst is synchronous; it clears valids and loads register reset values.
`default_nettype none
module db_heatmap_colormap_core (
  input  wire logic        clk,
  input  wire logic        rst,
  hcm_level_if.sink        level,
  hcm_pixel_if.source      pixel,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [63:0] thresh;
  logic [23:0] c0, c1, c2, c3, c4;
  logic [15:0] db_floor, db_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh     <= '0;
      c0         <= '0;
      c1         <= '0;
      c2         <= '0;
      c3         <= '0;
      c4         <= '0;
      db_floor   <= hcm_pkg::FLOOR_RESET;
      db_ceiling <= '0;
    end else if (cfg_we) begin
      case (hcm_pkg::hcm_reg_e'(cfg_index))
        hcm_pkg::REG_THRESH:  thresh     <= cfg_data;
        hcm_pkg::REG_COLOR_0: c0         <= cfg_data[23:0];
        hcm_pkg::REG_COLOR_1: c1         <= cfg_data[23:0];
        hcm_pkg::REG_COLOR_2: c2         <= cfg_data[23:0];
        hcm_pkg::REG_COLOR_3: c3         <= cfg_data[23:0];
        hcm_pkg::REG_COLOR_4: c4         <= cfg_data[23:0];
        hcm_pkg::REG_FLOOR:   db_floor   <= cfg_data[15:0];
        hcm_pkg::REG_CEILING: db_ceiling <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en          = !pixel.valid || pixel.ready;
  assign level.ready = en;

  // prep
  logic signed [16:0] d, span, lvl, flo;
  logic               frc;
  logic [15:0]        fv;

  always_comb begin
    lvl  = {level.db_value[15], level.db_value};
    flo  = {db_floor[15], db_floor};
    d    = lvl - flo;
    span = {db_ceiling[15], db_ceiling} - flo;
    frc  = 1'b1;
    fv   = '0;
    if (span <= 17'sd0) begin
      fv = (lvl < flo) ? 16'd0 : hcm_pkg::NORM_ONE;
    end else if (d <= 17'sd0) begin
      fv = 16'd0;
    end else if (d >= span) begin
      fv = hcm_pkg::NORM_ONE;
    end else begin
      frc = 1'b0;
    end
  end

  hcm_pkg::hcm_div_t ndiv [hcm_pkg::NORM_STEPS+1];
  logic              nvld [hcm_pkg::NORM_STEPS+1];
  logic              nfrc [hcm_pkg::NORM_STEPS+1];
  logic [15:0]       nfv  [hcm_pkg::NORM_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nvld[0] <= 1'b0;
    end else if (en) begin
      nvld[0] <= level.valid;
    end
    if (en) begin
      ndiv[0].rem <= d[15:0];
      ndiv[0].den <= span[15:0];
      ndiv[0].quo <= '0;
      nfrc[0]     <= frc;
      nfv[0]      <= fv;
    end
  end

  for (genvar i = 1; i <= hcm_pkg::NORM_STEPS; i++) begin : g_norm
    hcm_div_cell u_cell (.clk(clk), .en(en), .din(ndiv[i-1]), .dout(ndiv[i]));
    always_ff @(posedge clk) begin
      if (rst) begin
        nvld[i] <= 1'b0;
      end else if (en) begin
        nvld[i] <= nvld[i-1];
      end
      if (en) begin
        nfrc[i] <= nfrc[i-1];
        nfv[i]  <= nfv[i-1];
      end
    end
  end

  // segment select
  logic [15:0] v, t1, t2, t3, t4, lo, hi, num, den;
  logic [23:0] ca, cb;
  logic        bey;

  always_comb begin
    v  = nfrc[hcm_pkg::NORM_STEPS] ? nfv[hcm_pkg::NORM_STEPS]
                                   : {1'b0, ndiv[hcm_pkg::NORM_STEPS].quo[14:0]};
    t1 = thresh[15:0];
    t2 = thresh[31:16];
    t3 = thresh[47:32];
    t4 = thresh[63:48];
    bey = 1'b0;
    if (v < t1) begin
      lo = '0; hi = t1; ca = c0; cb = c1;
    end else if (v < t2) begin
      lo = t1; hi = t2; ca = c1; cb = c2;
    end else if (v < t3) begin
      lo = t2; hi = t3; ca = c2; cb = c3;
    end else if (v < t4) begin
      lo = t3; hi = t4; ca = c3; cb = c4;
    end else begin
      bey = 1'b1;
      lo = v; hi = v + 16'd1; ca = c4; cb = c4;
    end
    num = v - lo;
    den = hi - lo;
  end

  logic        svld, sbey;
  logic [15:0] snum, sden;
  logic [7:0]  sa   [hcm_pkg::NUM_CH];
  logic [7:0]  sdif [hcm_pkg::NUM_CH];
  logic        sneg [hcm_pkg::NUM_CH];

  logic        mvld, mbey;
  logic [7:0]  ma   [hcm_pkg::NUM_CH];
  logic        mneg [hcm_pkg::NUM_CH];

  hcm_pkg::hcm_div_t bdiv [hcm_pkg::NUM_CH][hcm_pkg::BLEND_STEPS+1];
  logic              bvld [hcm_pkg::BLEND_STEPS+1];
  logic              bbey [hcm_pkg::BLEND_STEPS+1];
  logic [7:0]        ba   [hcm_pkg::NUM_CH][hcm_pkg::BLEND_STEPS+1];
  logic              bneg [hcm_pkg::NUM_CH][hcm_pkg::BLEND_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      svld <= 1'b0;
      mvld <= 1'b0;
    end else if (en) begin
      svld <= nvld[hcm_pkg::NORM_STEPS];
      mvld <= svld;
    end
    if (en) begin
      sbey <= bey;
      snum <= num;
      sden <= den;
      mbey <= sbey;
    end
  end

  assign bvld[0] = mvld;
  assign bbey[0] = mbey;

  for (genvar c = 0; c < hcm_pkg::NUM_CH; c++) begin : g_ch
    logic [7:0]  xa, xb;
    logic [23:0] prod;
    assign xa   = ca[16-8*c +: 8];
    assign xb   = cb[16-8*c +: 8];
    assign prod = sdif[c] * snum;

    always_ff @(posedge clk) begin
      if (en) begin
        sa[c]   <= xa;
        sneg[c] <= xb < xa;
        sdif[c] <= (xb < xa) ? xa - xb : xb - xa;
        ma[c]   <= sa[c];
        mneg[c] <= sneg[c];
        bdiv[c][0].rem <= prod[23:8];
        bdiv[c][0].den <= sden;
        bdiv[c][0].quo <= {prod[7:0], 8'd0};
      end
    end

    assign ba[c][0]   = ma[c];
    assign bneg[c][0] = mneg[c];

    for (genvar j = 1; j <= hcm_pkg::BLEND_STEPS; j++) begin : g_blend
      hcm_div_cell u_cell (.clk(clk), .en(en), .din(bdiv[c][j-1]), .dout(bdiv[c][j]));
      always_ff @(posedge clk) begin
        if (en) begin
          ba[c][j]   <= ba[c][j-1];
          bneg[c][j] <= bneg[c][j-1];
        end
      end
    end
  end

  for (genvar j = 1; j <= hcm_pkg::BLEND_STEPS; j++) begin : g_bside
    always_ff @(posedge clk) begin
      if (rst) begin
        bvld[j] <= 1'b0;
      end else if (en) begin
        bvld[j] <= bvld[j-1];
      end
      if (en) begin
        bbey[j] <= bbey[j-1];
      end
    end
  end

  // output
  logic [7:0] res [hcm_pkg::NUM_CH];

  always_comb begin
    for (int c = 0; c < hcm_pkg::NUM_CH; c++) begin
      if (bbey[hcm_pkg::BLEND_STEPS]) begin
        res[c] = c4[16-8*c +: 8];
      end else if (bneg[c][hcm_pkg::BLEND_STEPS]) begin
        res[c] = ba[c][hcm_pkg::BLEND_STEPS]
               - bdiv[c][hcm_pkg::BLEND_STEPS].quo[7:0]
               - {7'd0, bdiv[c][hcm_pkg::BLEND_STEPS].rem != 16'd0};
      end else begin
        res[c] = ba[c][hcm_pkg::BLEND_STEPS] + bdiv[c][hcm_pkg::BLEND_STEPS].quo[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (en) begin
      pixel.valid <= bvld[hcm_pkg::BLEND_STEPS];
    end
    if (en) begin
      pixel.red   <= res[0];
      pixel.green <= res[1];
      pixel.blue  <= res[2];
    end
  end

`ifndef SYNTHESIS
  a_rst_clears: assert property (@(posedge clk) rst |=> !pixel.valid)
    else $error("pixel valid after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      (pixel.valid && !pixel.ready) |=> $stable(bvld[hcm_pkg::BLEND_STEPS]))
    else $error("pipeline moved during stall");
  a_norm_rem: assert property (@(posedge clk) disable iff (rst)
      (nvld[hcm_pkg::NORM_STEPS] && !nfrc[hcm_pkg::NORM_STEPS]) |->
      (ndiv[hcm_pkg::NORM_STEPS].rem < ndiv[hcm_pkg::NORM_STEPS].den))
    else $error("normalize remainder not below divisor");
`endif
endmodule
`default_nettype wire
